// ===== design/srsb_pkg.sv =====
package srsb_pkg;

  // ring geometry, always a power of two so a slot is the low offset bits
  localparam int RING_AW      = 12;
  localparam int BUFFER_BYTES = 1 << RING_AW;

  // longest burst a single fetch may return
  localparam int MAX_FETCH = 16;
  localparam int FETCH_W   = $clog2(MAX_FETCH + 1);

  localparam int OFF_W  = 62;
  localparam int AMT_W  = 13;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FETCH  = 2'd1,
    OP_SENT   = 2'd2,
    OP_ACK    = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DATA    = 2'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data_byte;
    logic [AMT_W-1:0]   amount;
    logic [FETCH_W-1:0] fetch_cap;
    logic [OFF_W-1:0]   ack_offset;
  } item_t;

endpackage

// ===== design/srsb_front.sv =====
module srsb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srsb_pkg::CMD_W-1:0]      cmd,
  input  logic [srsb_pkg::BYTE_W-1:0]     data_byte,
  input  logic [srsb_pkg::AMT_W-1:0]      amount,
  input  logic [srsb_pkg::OFF_W-1:0]      ack_offset,
  output srsb_pkg::item_t                 q_item,
  output logic                            q_valid,
  input  logic                            q_pop
);

  srsb_pkg::item_t                entries [srsb_pkg::QDEPTH];
  logic [srsb_pkg::QAW-1:0]       wr_ptr;
  logic [srsb_pkg::QAW-1:0]       rd_ptr;
  logic [srsb_pkg::QCNT_W-1:0]    count;
  srsb_pkg::item_t                dec;
  logic                           accept;

  // classify the command and pre-cap the fetch budget
  always_comb begin
    dec.op         = srsb_pkg::op_t'(cmd);
    dec.data_byte  = data_byte;
    dec.amount     = amount;
    dec.ack_offset = ack_offset;
    if (amount > srsb_pkg::AMT_W'(srsb_pkg::MAX_FETCH)) begin
      dec.fetch_cap = srsb_pkg::FETCH_W'(srsb_pkg::MAX_FETCH);
    end else begin
      dec.fetch_cap = amount[srsb_pkg::FETCH_W-1:0];
    end
  end

  assign in_stall = (count == srsb_pkg::QCNT_W'(srsb_pkg::QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + srsb_pkg::QAW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + srsb_pkg::QAW'(1);
      end
      if (accept && !q_pop) begin
        count <= count + srsb_pkg::QCNT_W'(1);
      end else if (!accept && q_pop) begin
        count <= count - srsb_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/srsb_back.sv =====
module srsb_back (
  input  logic                            clk,
  input  logic                            rst,
  input  srsb_pkg::item_t                 q_item,
  input  logic                            q_valid,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srsb_pkg::BYTE_W-1:0]     out_byte,
  output logic [srsb_pkg::OFF_W-1:0]      byte_offset,
  output logic [srsb_pkg::STAT_W-1:0]     status,
  output logic                            last
);

  localparam int SUM_W = srsb_pkg::OFF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FSETUP,
    S_FETCH,
    S_SENT_SUM,
    S_SENT,
    S_ACK_CLAMP,
    S_ACK
  } state_t;

  state_t                         state;
  srsb_pkg::item_t                cur;
  logic [srsb_pkg::OFF_W-1:0]     end_off;
  logic [srsb_pkg::OFF_W-1:0]     sent_off;
  logic [srsb_pkg::OFF_W-1:0]     acked_off;
  logic [srsb_pkg::OFF_W-1:0]     off_cur;
  logic [srsb_pkg::OFF_W-1:0]     ack_c;
  logic [SUM_W-1:0]               sum;
  logic [srsb_pkg::FETCH_W-1:0]   cnt;
  logic [srsb_pkg::FETCH_W-1:0]   fetch_n;

  logic [srsb_pkg::BYTE_W-1:0]    ring [srsb_pkg::BUFFER_BYTES];
  logic [srsb_pkg::BYTE_W-1:0]    rd_data;

  logic                           o_valid;
  logic [srsb_pkg::BYTE_W-1:0]    o_byte;
  logic [srsb_pkg::OFF_W-1:0]     o_offset;
  logic [srsb_pkg::STAT_W-1:0]    o_status;
  logic                           o_last;

  logic                           out_free;
  logic                           emit;
  logic [srsb_pkg::OFF_W-1:0]     pending;
  logic [srsb_pkg::OFF_W-1:0]     fill;
  logic                           ring_full;
  logic                           no_fetch;
  logic [srsb_pkg::FETCH_W-1:0]   fetch_n_c;
  logic                           fetch_last;
  logic [srsb_pkg::OFF_W-1:0]     sent_clamped;
  logic                           ack_raise;
  logic                           wr_en;
  logic                           rd_en;
  logic [srsb_pkg::RING_AW-1:0]   rd_addr;

  always_comb begin
    out_free  = !o_valid || !out_stall;
    pending   = end_off - sent_off;
    fill      = end_off - acked_off;
    ring_full = (fill >= srsb_pkg::OFF_W'(srsb_pkg::BUFFER_BYTES)) ||
                (end_off == srsb_pkg::OFF_MAX);
    no_fetch  = (pending == '0) || (cur.fetch_cap == '0);
    if (pending >= srsb_pkg::OFF_W'(cur.fetch_cap)) begin
      fetch_n_c = cur.fetch_cap;
    end else begin
      fetch_n_c = pending[srsb_pkg::FETCH_W-1:0];
    end
    fetch_last = (cnt == fetch_n - srsb_pkg::FETCH_W'(1));
    if (sum > {1'b0, end_off}) begin
      sent_clamped = end_off;
    end else begin
      sent_clamped = sum[srsb_pkg::OFF_W-1:0];
    end
    ack_raise = (ack_c > acked_off);
    // a result is loaded into the output register this cycle
    emit      = out_free && ((state == S_APPEND) || (state == S_FSETUP && no_fetch) ||
                             (state == S_FETCH) || (state == S_SENT) || (state == S_ACK));
    q_pop     = (state == S_IDLE) && q_valid;
    wr_en     = (state == S_APPEND) && out_free && !ring_full;
    rd_en     = 1'b0;
    rd_addr   = sent_off[srsb_pkg::RING_AW-1:0];
    if (state == S_FSETUP && !no_fetch) begin
      rd_en = 1'b1;
    end else if (state == S_FETCH && out_free && !fetch_last) begin
      rd_en   = 1'b1;
      rd_addr = off_cur[srsb_pkg::RING_AW-1:0] + srsb_pkg::RING_AW'(1);
    end
  end

  // byte ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[end_off[srsb_pkg::RING_AW-1:0]] <= cur.data_byte;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      end_off   <= '0;
      sent_off  <= '0;
      acked_off <= '0;
      o_valid   <= 1'b0;
    end else begin
      o_valid <= emit || (o_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            case (q_item.op)
              srsb_pkg::OP_APPEND: state <= S_APPEND;
              srsb_pkg::OP_FETCH:  state <= S_FSETUP;
              srsb_pkg::OP_SENT:   state <= S_SENT_SUM;
              srsb_pkg::OP_ACK:    state <= S_ACK_CLAMP;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_APPEND: begin
          if (out_free) begin
            o_byte   <= '0;
            o_offset <= end_off;
            o_status <= ring_full ? srsb_pkg::ST_REFUSED : srsb_pkg::ST_DONE;
            o_last   <= 1'b1;
            if (!ring_full) begin
              end_off <= end_off + srsb_pkg::OFF_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_FSETUP: begin
          if (no_fetch) begin
            if (out_free) begin
              o_byte   <= '0;
              o_offset <= sent_off;
              o_status <= srsb_pkg::ST_EMPTY;
              o_last   <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            fetch_n <= fetch_n_c;
            cnt     <= '0;
            off_cur <= sent_off;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (out_free) begin
            o_byte   <= rd_data;
            o_offset <= off_cur;
            o_status <= srsb_pkg::ST_DATA;
            o_last   <= fetch_last;
            if (fetch_last) begin
              state <= S_IDLE;
            end else begin
              cnt     <= cnt + srsb_pkg::FETCH_W'(1);
              off_cur <= off_cur + srsb_pkg::OFF_W'(1);
            end
          end
        end
        S_SENT_SUM: begin
          sum   <= {1'b0, sent_off} + SUM_W'(cur.amount);
          state <= S_SENT;
        end
        S_SENT: begin
          if (out_free) begin
            sent_off <= sent_clamped;
            o_byte   <= '0;
            o_offset <= sent_clamped;
            o_status <= srsb_pkg::ST_DONE;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_ACK_CLAMP: begin
          ack_c <= (cur.ack_offset > end_off) ? end_off : cur.ack_offset;
          state <= S_ACK;
        end
        S_ACK: begin
          if (out_free) begin
            if (ack_raise) begin
              acked_off <= ack_c;
              if (sent_off < ack_c) begin
                sent_off <= ack_c;
              end
            end
            o_byte   <= '0;
            o_offset <= ack_raise ? ack_c : acked_off;
            o_status <= srsb_pkg::ST_DONE;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = o_valid;
  assign out_byte    = o_byte;
  assign byte_offset = o_offset;
  assign status      = o_status;
  assign last        = o_last;

endmodule

// ===== design/stream_retransmit_send_buffer_unit.sv =====
// send buffer of one transport stream over a 4096-byte ring
//
// input channel (in_valid / in_stall): one command per transfer, cmd picks
// append, fetch, mark sent or acknowledge; data_byte, amount and ack_offset
// ride along and are used by the command that needs them
// output channel (out_valid / out_stall): one result per transfer, a fetch
// gives a burst of up to 16 data results, every other command gives one;
// last marks the final result of each command
// a two-entry command queue separates the front from the executing back
// part, so input transfers go on while the output is stalled until the
// queue fills, then in_stall rises
// on an idle block, a command goes from the queue entry into the back part's
// state and then, for append and for a fetch with nothing to send, into the
// output register; a fetch with data first reads the ring, mark sent and
// acknowledge first do a wide add or clamp, then the update; a fetch with
// data then loads one data result per byte into the output register
// a stalled output holds its result; the back part waits and the queue
// absorbs up to two more commands
// reset (rst, synchronous) zeroes all three stream offsets and empties the
// queue; ring contents are left as they are
module stream_retransmit_send_buffer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srsb_pkg::CMD_W-1:0]      cmd,
  input  logic [srsb_pkg::BYTE_W-1:0]     data_byte,
  input  logic [srsb_pkg::AMT_W-1:0]      amount,
  input  logic [srsb_pkg::OFF_W-1:0]      ack_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srsb_pkg::BYTE_W-1:0]     out_byte,
  output logic [srsb_pkg::OFF_W-1:0]      byte_offset,
  output logic [srsb_pkg::STAT_W-1:0]     status,
  output logic                            last
);

  // queued command between front and back
  srsb_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // front: classify commands and hold them in the short queue
  srsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .amount     (amount),
    .ack_offset (ack_offset),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  // back: offsets, byte ring and the output register
  srsb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_offset (byte_offset),
    .status      (status),
    .last        (last)
  );

endmodule

// ===== design/srsb_checker.sv =====
module srsb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [srsb_pkg::CMD_W-1:0]      cmd,
  input logic [srsb_pkg::BYTE_W-1:0]     data_byte,
  input logic [srsb_pkg::AMT_W-1:0]      amount,
  input logic [srsb_pkg::OFF_W-1:0]      ack_offset,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [srsb_pkg::BYTE_W-1:0]     out_byte,
  input logic [srsb_pkg::OFF_W-1:0]      byte_offset,
  input logic [srsb_pkg::STAT_W-1:0]     status,
  input logic                            last
);

  // stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_offset) &&
    $stable(status) && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  // a fetch burst streams without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && status == srsb_pkg::ST_DATA && !last |=>
    out_valid && status == srsb_pkg::ST_DATA &&
    byte_offset == $past(byte_offset) + srsb_pkg::OFF_W'(1))
    else $error("fetch burst broken");

  // only data results carry a byte and may be non-final
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != srsb_pkg::ST_DATA |-> last && out_byte == '0)
    else $error("single result malformed");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stream_retransmit_send_buffer_unit srsb_checker u_srsb_checker (.*);

// ===== tb/send_buffer_checker.sv =====
module send_buffer_checker
  import srsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [AMT_W-1:0]   amount,
  input  logic [OFF_W-1:0]   ack_offset,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [BYTE_W-1:0]  out_byte,
  input  logic [OFF_W-1:0]   byte_offset,
  input  logic [STAT_W-1:0]  status,
  input  logic               last,
  output int                 mismatch_count,
  output int                 results_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [OFF_W-1:0]  offset;
    logic [STAT_W-1:0] code;
    logic              is_last;
  } result_t;

  // shadow of the stream state
  logic [BYTE_W-1:0] ring_copy [BUFFER_BYTES];
  logic [OFF_W-1:0]  end_off;
  logic [OFF_W-1:0]  sent_off;
  logic [OFF_W-1:0]  acked_off;

  result_t awaited_results [$];
  int      mismatches = 0;

  task automatic apply_command(input op_t op, input logic [BYTE_W-1:0] d,
                               input logic [AMT_W-1:0] amt,
                               input logic [OFF_W-1:0] ack);
    logic [OFF_W-1:0] span;
    logic [OFF_W-1:0] moved;
    logic [OFF_W:0]   wide;
    int               n;
    case (op)
      OP_APPEND: begin
        if (end_off - acked_off >= OFF_W'(BUFFER_BYTES) || end_off == OFF_MAX) begin
          awaited_results.push_back('{'0, end_off, ST_REFUSED, 1'b1});
        end else begin
          ring_copy[end_off[RING_AW-1:0]] = d;
          awaited_results.push_back('{'0, end_off, ST_DONE, 1'b1});
          end_off = end_off + OFF_W'(1);
        end
      end
      OP_FETCH: begin
        span = end_off - sent_off;
        if (span == '0 || amt == '0) begin
          awaited_results.push_back('{'0, sent_off, ST_EMPTY, 1'b1});
        end else begin
          n = MAX_FETCH;
          if (amt < n) n = int'(amt);
          if (span < OFF_W'(n)) n = int'(span);
          for (int k = 0; k < n; k++) begin
            moved = sent_off + OFF_W'(k);
            awaited_results.push_back('{ring_copy[moved[RING_AW-1:0]], moved, ST_DATA,
                                        (k == n - 1)});
          end
        end
      end
      OP_SENT: begin
        // one bit wider so the sum never wraps before the clamp
        wide = {1'b0, sent_off} + (OFF_W+1)'(amt);
        sent_off = (wide > {1'b0, end_off}) ? end_off : wide[OFF_W-1:0];
        awaited_results.push_back('{'0, sent_off, ST_DONE, 1'b1});
      end
      default: begin
        moved = (ack > end_off) ? end_off : ack;
        if (moved > acked_off) begin
          acked_off = moved;
          if (sent_off < acked_off) sent_off = acked_off;
        end
        awaited_results.push_back('{'0, acked_off, ST_DONE, 1'b1});
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      end_off   = '0;
      sent_off  = '0;
      acked_off = '0;
      awaited_results.delete();
    end else begin
      // results first, so a stray result is never matched to a fresh command
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual offset %0h status %0h",
                   $time, byte_offset, status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %0h actual %0h", $time, want.data, out_byte);
            mismatches++;
          end
          if (byte_offset !== want.offset) begin
            $display("%0t: byte_offset expected %0h actual %0h",
                     $time, want.offset, byte_offset);
            mismatches++;
          end
          if (status !== want.code) begin
            $display("%0t: status expected %0h actual %0h", $time, want.code, status);
            mismatches++;
          end
          if (last !== want.is_last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.is_last, last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) apply_command(op_t'(cmd), data_byte, amount, ack_offset);
    end
    results_left   <= awaited_results.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== tb/stream_retransmit_send_buffer_unit_test.sv =====
module stream_retransmit_send_buffer_unit_test;
  import srsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // longest stretch with no transfer on either channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // length of the forced output hold-off
  localparam int HOLD_CYCLES    = 64;
  // appends offered while the output is held off
  localparam int FILL_ITEMS     = 24;
  // random commands per idling phase
  localparam int PHASE_ITEMS    = 35;
  // quiet cycles after the last result, covers the deepest back-end latency
  localparam int TAIL_CYCLES    = 20;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd        = '0;
  logic [BYTE_W-1:0] data_byte  = '0;
  logic [AMT_W-1:0]  amount     = '0;
  logic [OFF_W-1:0]  ack_offset = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic [OFF_W-1:0]  byte_offset;
  logic [STAT_W-1:0] status;
  logic              last;

  int mismatch_count;
  int results_left;

  // idling knobs: idle_pct belongs to the sender process alone,
  // stall_pct and hold_go are handed to the receiver process by nonblocking writes
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_go   = 1'b0;
  int   hold_cnt  = 0;
  int   quiet     = 0;

  // rough write end, only used to aim acknowledge offsets near the window
  logic [OFF_W-1:0] stream_end = '0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  stream_retransmit_send_buffer_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .amount      (amount),
    .ack_offset  (ack_offset),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_offset (byte_offset),
    .status      (status),
    .last        (last)
  );

  send_buffer_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .amount         (amount),
    .ack_offset     (ack_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .byte_offset    (byte_offset),
    .status         (status),
    .last           (last),
    .mismatch_count (mismatch_count),
    .results_left   (results_left)
  );

  // receiver: a forced hold-off counted here, otherwise random stalls
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      if (!hold_go) hold_cnt <= 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("stream_retransmit_send_buffer_unit_test: errors");
        $finish;
      end
    end
  end

  function automatic logic [OFF_W-1:0] rand_offset();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[OFF_W-1:0];
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    idle_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  // one command transfer; valid stays up between back-to-back commands
  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] d,
                           input logic [AMT_W-1:0] amt, input logic [OFF_W-1:0] ack);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    data_byte  <= d;
    amount     <= amt;
    ack_offset <= ack;
    do @(posedge clk); while (in_stall);
    if (op == OP_APPEND) stream_end += OFF_W'(1);
  endtask

  // sender pauses until every awaited result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_left != 0);
  endtask

  // mostly meaningful commands with random content; unused fields carry noise
  task automatic random_item();
    int               pick;
    op_t              op;
    logic [AMT_W-1:0] amt;
    logic [OFF_W-1:0] ack;
    pick = $urandom_range(99);
    amt  = AMT_W'($urandom_range(BUFFER_BYTES));
    ack  = rand_offset();
    if (pick < 40) begin
      op = OP_APPEND;
    end else if (pick < 62) begin
      op = OP_FETCH;
      case ($urandom_range(9))
        0:       amt = '0;
        1:       amt = AMT_W'(MAX_FETCH);
        2, 3:    ;
        default: amt = AMT_W'($urandom_range(1, 20));
      endcase
    end else if (pick < 80) begin
      op = OP_SENT;
      if ($urandom_range(4) != 0) amt = AMT_W'($urandom_range(6));
    end else begin
      op = OP_ACK;
      case ($urandom_range(9))
        0:       ack = '0;
        1:       ;
        2:       ack = stream_end + OFF_W'($urandom_range(1, 4));
        default: begin
          // just behind the write end, sometimes behind the acked point too
          ack = stream_end - OFF_W'($urandom_range(8));
          if (stream_end < OFF_W'(8)) ack = stream_end;
        end
      endcase
    end
    send_item(op, BYTE_W'($urandom), amt, ack);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty stream first
    send_item(OP_FETCH, 8'h3c, 13'd5, '0);
    send_item(OP_SENT, 8'h00, 13'd4096, '0);
    send_item(OP_ACK, 8'hff, 13'd0, '0);
    send_item(OP_ACK, 8'h00, 13'd4095, OFF_MAX);
    // extreme bytes, then enough to overrun one fetch burst
    send_item(OP_APPEND, 8'h00, 13'd4096, OFF_MAX);
    send_item(OP_APPEND, 8'hff, 13'd0, '0);
    for (int i = 0; i < MAX_FETCH - 1; i++)
      send_item(OP_APPEND, BYTE_W'($urandom), '0, '0);
    // zero budget with bytes pending, full budget capped, short budget
    send_item(OP_FETCH, 8'h00, 13'd0, '0);
    send_item(OP_FETCH, 8'h00, 13'd4096, '0);
    send_item(OP_FETCH, 8'h00, 13'd3, '0);
    send_item(OP_SENT, 8'h00, 13'd1, '0);
    send_item(OP_FETCH, 8'h00, 13'd4095, '0);
    // acknowledge past the end clamps to it, leaving nothing pending
    send_item(OP_ACK, 8'h00, 13'd0, OFF_MAX);
    send_item(OP_FETCH, 8'h00, 13'd16, '0);
    wait_drained();

    // long output hold-off: the command queue backs up and in_stall has
    // to rise while appends keep coming
    hold_go <= 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++)
      send_item(OP_APPEND, BYTE_W'($urandom), AMT_W'($urandom), rand_offset());
    hold_go <= 1'b0;
    // fetch the backlog, acknowledge part of it, then walk sent to the end
    send_item(OP_FETCH, 8'h00, 13'd4096, '0);
    send_item(OP_ACK, 8'h00, '0, OFF_W'(24));
    send_item(OP_FETCH, 8'h00, 13'd4096, '0);
    send_item(OP_SENT, 8'h00, 13'd4096, '0);
    send_item(OP_FETCH, 8'h00, 13'd7, '0);
    send_item(OP_APPEND, 8'hc3, '0, '0);
    send_item(OP_FETCH, 8'h00, 13'd4096, '0);
    send_item(OP_ACK, 8'h00, '0, OFF_MAX);
    wait_drained();

    // random phases: no idling, sender idle, receiver stalling, both
    set_idling(0, 0);
    repeat (PHASE_ITEMS) random_item();
    set_idling(88, 0);
    repeat (PHASE_ITEMS) random_item();
    set_idling(0, 88);
    repeat (PHASE_ITEMS) random_item();
    set_idling(14, 14);
    repeat (PHASE_ITEMS) random_item();

    stall_pct <= 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_left == 0) begin
      $display("stream_retransmit_send_buffer_unit_test: clean");
    end else begin
      $display("stream_retransmit_send_buffer_unit_test: errors");
    end
    $finish;
  end

endmodule
